// ===== src/kls_pkg.sv =====
// Shared types, codes and keyword tables of the keyword line spam classifier.
`timescale 1ns / 1ps

package kls_pkg;

    // Byte, line length and verdict widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 8;
    localparam int VERDICT_W = 2;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAX_LINE_LENGTH = 1'b0;   // register index, paddr[2]
    localparam logic [LEN_W-1:0] MAX_LINE_LENGTH_RESET = 8'd76;
    localparam logic [LEN_W-1:0] LEN_SATURATED = 8'hFF;

    // Control characters
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_INBOX     = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_LONG_LINE = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_MULTI_KW  = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TWO_LINES = 2'd3;

    // Keyword table: text stored first character first
    localparam int TABLE_SLOTS = 12;
    localparam int KW_MAX      = 8;

    typedef logic [BYTE_W-1:0] t_kw_row [KW_MAX];

    localparam t_kw_row KW_TEXT [TABLE_SLOTS] = '{
        '{"g", "r", "a", "t", "u", "i", "t", 8'h00},
        '{"a", "t", "e", "n", "c", 8'h00, 8'h00, 8'h00},
        '{"u", "r", "g", "e", "n", "t", "e", 8'h00},
        '{"i", "m", "e", "d", "i", "a", "t", 8'h00},
        '{"z", "o", "o", "m", "b", "i", "e", 8'h00},
        '{"o", "f", "e", "r", "t", "a", 8'h00, 8'h00},
        '{"d", "i", "n", "h", "e", "i", "r", "o"},
        '{"r", "e", "n", "d", "a", 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "d", "o", 8'h00, 8'h00, 8'h00},
        '{"l", "i", "m", "i", "t", "a", "d", 8'h00},
        '{"a", "j", "u", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "O", "S", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam int KW_LEN [TABLE_SLOTS] = '{7, 5, 7, 7, 7, 6, 8, 5, 5, 7, 4, 3};

    // Outcome of closing a line
    typedef struct packed {
        logic [VERDICT_W-1:0] reason;
        logic                 earlier_hit;
    } t_close;

endpackage

// ===== src/kls_matcher.sv =====
// Parallel keyword comparators over the current byte and the line history.
`timescale 1ns / 1ps

module kls_matcher #(
    parameter int NUM_KEYWORDS  = 12,
    parameter int HISTORY_BYTES = 7
) (
    input  logic [kls_pkg::BYTE_W-1:0] i_byte,
    input  logic [kls_pkg::BYTE_W-1:0] i_history [HISTORY_BYTES],
    output logic [NUM_KEYWORDS-1:0]    o_hits
);

    // One comparator row per keyword; newest history byte sits at index 0
    for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_kw
        if (k < kls_pkg::TABLE_SLOTS) begin : g_slot
            localparam int L = kls_pkg::KW_LEN[k];
            if (L > 0 && L <= kls_pkg::KW_MAX && L <= HISTORY_BYTES + 1) begin : g_fit
                logic [L-1:0] eq;
                // last keyword character against the incoming byte
                assign eq[0] = (i_byte == kls_pkg::KW_TEXT[k][L-1]);
                // earlier characters against the history, newest first
                for (genvar j = 1; j < L; j++) begin : g_cmp
                    assign eq[j] = (i_history[j-1] == kls_pkg::KW_TEXT[k][L-1-j]);
                end
                assign o_hits[k] = &eq;
            end else begin : g_nofit
                assign o_hits[k] = 1'b0;
            end
        end else begin : g_empty
            assign o_hits[k] = 1'b0;
        end
    end

endmodule

// ===== src/kls_line_close.sv =====
// Verdict update applied when a line closes.
`timescale 1ns / 1ps

module kls_line_close #(
    parameter int NUM_KEYWORDS = 12
) (
    input  logic [NUM_KEYWORDS-1:0]       i_found,
    input  logic [kls_pkg::LEN_W-1:0]     i_line_length,
    input  logic [kls_pkg::LEN_W-1:0]     i_max_line_length,
    input  logic                          i_earlier_hit,
    input  logic [kls_pkg::VERDICT_W-1:0] i_reason,
    output kls_pkg::t_close               o_close
);

    logic any_kw;
    logic multi_kw;

    // Two or more distinct keywords: clearing the lowest set bit leaves one
    assign any_kw   = |i_found;
    assign multi_kw = |(i_found & (i_found - {{(NUM_KEYWORDS-1){1'b0}}, 1'b1}));

    // Latch the first reason that applies; hold once a verdict is set
    always_comb begin
        o_close.reason      = i_reason;
        o_close.earlier_hit = i_earlier_hit;
        if (i_reason == kls_pkg::VERDICT_INBOX) begin
            if (i_line_length > i_max_line_length) begin
                o_close.reason = kls_pkg::VERDICT_LONG_LINE;
            end else if (multi_kw) begin
                o_close.reason = kls_pkg::VERDICT_MULTI_KW;
            end else if (any_kw && i_earlier_hit) begin
                o_close.reason = kls_pkg::VERDICT_TWO_LINES;
            end else if (any_kw) begin
                o_close.earlier_hit = 1'b1;
            end
        end
    end

endmodule

// ===== src/keyword_line_spam_classifier.sv =====
// Top level of the keyword line spam classifier.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one message byte per
//   request in i_char_byte; a request with i_end_of_message high ends the
//   message and its byte is ignored. Carriage returns are dropped, a line feed
//   closes the current line.
//   Output channel (o_out_valid / i_out_ready) carries one o_verdict per
//   message: 0 inbox, 1 line too long, 2 two keywords in one line,
//   3 keywords in two lines.
//   The APB-style port holds max_line_length at byte address 0; write it
//   only while no message is in flight.
//   The verdict is registered and valid in the cycle after the end-of-message
//   request is accepted. Throughput: one byte per cycle; the keyword
//   comparators feed the line state registers, and the line close decision
//   sits between the line state registers and the verdict register.
//   If the receiver stalls, the verdict is held in its register and byte
//   requests are still taken; only the next end-of-message request waits.
//   Reset clears all line and message state, drops any pending verdict and
//   sets max_line_length to 76. After each verdict the message state clears
//   but the register keeps its value.
module keyword_line_spam_classifier #(
    parameter int NUM_KEYWORDS  = 12,
    parameter int HISTORY_BYTES = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [kls_pkg::BYTE_W-1:0]        i_char_byte,
    input  logic                              i_end_of_message,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [kls_pkg::VERDICT_W-1:0]     o_verdict,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kls_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kls_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kls_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    // Line and message state
    logic [kls_pkg::BYTE_W-1:0]    r_hist [HISTORY_BYTES];
    logic [kls_pkg::BYTE_W-1:0]    n_hist [HISTORY_BYTES];
    logic [NUM_KEYWORDS-1:0]       r_found, n_found;
    logic [kls_pkg::LEN_W-1:0]     r_len, n_len;
    logic                          r_pending, n_pending;
    logic                          r_earlier, n_earlier;
    logic [kls_pkg::VERDICT_W-1:0] r_reason, n_reason;
    // Verdict register
    logic                          r_out_valid, n_out_valid;
    logic [kls_pkg::VERDICT_W-1:0] r_verdict, n_verdict;
    // Configuration
    logic [kls_pkg::LEN_W-1:0]     r_max_len;

    logic                  in_accept;
    logic                  cfg_write;
    logic [NUM_KEYWORDS-1:0] hits;
    kls_pkg::t_close       close_res;

    // Byte requests never touch the verdict register; only end of message waits for it
    assign o_in_ready  = !r_out_valid || i_out_ready || !i_end_of_message;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // Configuration register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == kls_pkg::REG_MAX_LINE_LENGTH);
    assign prdata    = (paddr[2] == kls_pkg::REG_MAX_LINE_LENGTH)
                     ? {{(kls_pkg::APB_DATA_W-kls_pkg::LEN_W){1'b0}}, r_max_len}
                     : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= kls_pkg::MAX_LINE_LENGTH_RESET;
        end else if (cfg_write) begin
            r_max_len <= pwdata[kls_pkg::LEN_W-1:0];
        end
    end

    // Keyword comparators
    kls_matcher #(
        .NUM_KEYWORDS  (NUM_KEYWORDS),
        .HISTORY_BYTES (HISTORY_BYTES)
    ) u_matcher (
        .i_byte    (i_char_byte),
        .i_history (r_hist),
        .o_hits    (hits)
    );

    // Line close decision
    kls_line_close #(
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_line_close (
        .i_found           (r_found),
        .i_line_length     (r_len),
        .i_max_line_length (r_max_len),
        .i_earlier_hit     (r_earlier),
        .i_reason          (r_reason),
        .o_close           (close_res)
    );

    // Next state for one request
    always_comb begin
        n_hist      = r_hist;
        n_found     = r_found;
        n_len       = r_len;
        n_pending   = r_pending;
        n_earlier   = r_earlier;
        n_reason    = r_reason;
        n_out_valid = r_out_valid && !i_out_ready;
        n_verdict   = r_verdict;
        if (in_accept) begin
            if (i_end_of_message) begin
                // close a pending line, emit the verdict, clear the message
                n_verdict   = r_pending ? close_res.reason : r_reason;
                n_out_valid = 1'b1;
                n_hist      = '{default: '0};
                n_found     = '0;
                n_len       = '0;
                n_pending   = 1'b0;
                n_earlier   = 1'b0;
                n_reason    = kls_pkg::VERDICT_INBOX;
            end else if (i_char_byte == kls_pkg::CHAR_CR) begin
                // drop carriage returns
                n_pending = r_pending;
            end else if (i_char_byte == kls_pkg::CHAR_LF) begin
                // close the line and clear its state
                n_reason  = close_res.reason;
                n_earlier = close_res.earlier_hit;
                n_hist    = '{default: '0};
                n_found   = '0;
                n_len     = '0;
                n_pending = 1'b0;
            end else begin
                // take an ordinary byte: record hits, advance history and length
                n_found = r_found | hits;
                n_hist[0] = i_char_byte;
                for (int i = 1; i < HISTORY_BYTES; i++) begin
                    n_hist[i] = r_hist[i-1];
                end
                n_len     = (r_len == kls_pkg::LEN_SATURATED) ? r_len
                          : r_len + {{(kls_pkg::LEN_W-1){1'b0}}, 1'b1};
                n_pending = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '{default: '0};
            r_found     <= '0;
            r_len       <= '0;
            r_pending   <= 1'b0;
            r_earlier   <= 1'b0;
            r_reason    <= kls_pkg::VERDICT_INBOX;
            r_out_valid <= 1'b0;
        end else begin
            r_hist      <= n_hist;
            r_found     <= n_found;
            r_len       <= n_len;
            r_pending   <= n_pending;
            r_earlier   <= n_earlier;
            r_reason    <= n_reason;
            r_out_valid <= n_out_valid;
        end
    end

    // Verdict payload needs no reset
    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

endmodule

// ===== src/kls_checker.sv =====
// Port-level checks of the keyword line spam classifier and their binding.
`timescale 1ns / 1ps

module kls_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_end_of_message,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [kls_pkg::VERDICT_W-1:0] o_verdict
);

    // Reset drops any pending verdict
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("verdict valid after reset");

    // A stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict))
        else $error("stalled verdict changed");

    // A new verdict only follows an accepted end-of-message request
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_end_of_message))
        else $error("verdict without end of message");

    // A byte request raises no verdict
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_end_of_message && (!o_out_valid || i_out_ready)
        |=> !o_out_valid)
        else $error("verdict from a byte request");

    // Input stays open whenever the verdict register is empty
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty verdict register");

endmodule

bind keyword_line_spam_classifier kls_checker u_kls_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_end_of_message (i_end_of_message),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_verdict        (o_verdict)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the keyword line spam classifier: table, random messages, APB.
`timescale 1ns / 1ps

module testbench;

    localparam int KW_COUNT   = 12;
    localparam int HIST_DEPTH = 7;
    localparam int LIMIT_NS   = 3_000_000;
    localparam int HOLD_CYCLES = 400;

    // Directed rows: typed verdict, or left to the predictor
    localparam logic [2:0] WANT_PREDICT = 3'b100;
    localparam logic [2:0] WANT_INBOX   = {1'b0, kls_pkg::VERDICT_INBOX};
    localparam logic [2:0] WANT_LONG    = {1'b0, kls_pkg::VERDICT_LONG_LINE};

    typedef struct packed {
        logic       cfg;      // write max_line_length with data instead of sending
        logic [7:0] data;
        logic       eom;
        logic [2:0] want;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [kls_pkg::BYTE_W-1:0]     i_char_byte = '0;
    logic                           i_end_of_message = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [kls_pkg::VERDICT_W-1:0]  o_verdict;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [kls_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [kls_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [kls_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    keyword_line_spam_classifier uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_char_byte(i_char_byte), .i_end_of_message(i_end_of_message),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_verdict(o_verdict),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    string kw_words [KW_COUNT] = '{"gratuit", "atenc", "urgente", "imediat", "zoombie",
        "oferta", "dinheiro", "renda", "fundo", "limitad", "ajud", "SOS"};
    string filler_chars = "aeioudgrtnczmbfhlsjSOU";

    t_row dir_rows [28] = '{
        '{1'b0, 8'hFF, 1'b1, WANT_INBOX},            // message straight after reset
        '{1'b0, "S", 1'b0, WANT_PREDICT},
        '{1'b0, "O", 1'b0, WANT_PREDICT},
        '{1'b0, kls_pkg::CHAR_CR, 1'b0, WANT_PREDICT}, // carriage return inside a keyword
        '{1'b0, "S", 1'b0, WANT_PREDICT},
        '{1'b0, kls_pkg::CHAR_LF, 1'b0, WANT_PREDICT},
        '{1'b0, "a", 1'b0, WANT_PREDICT},
        '{1'b0, "j", 1'b0, WANT_PREDICT},
        '{1'b0, "u", 1'b0, WANT_PREDICT},
        '{1'b0, "d", 1'b0, WANT_PREDICT},
        '{1'b0, 8'h00, 1'b1, WANT_PREDICT},          // keywords in two lines
        '{1'b0, 8'hFF, 1'b0, WANT_PREDICT},          // 0xFF and 0x00 are ordinary bytes
        '{1'b0, 8'h00, 1'b0, WANT_PREDICT},
        '{1'b0, kls_pkg::CHAR_LF, 1'b1, WANT_PREDICT},
        '{1'b1, 8'd0, 1'b0, WANT_PREDICT},           // limit at its lowest
        '{1'b0, "x", 1'b0, WANT_PREDICT},
        '{1'b0, 8'h55, 1'b1, WANT_LONG},             // one byte closed by end of message
        '{1'b0, kls_pkg::CHAR_LF, 1'b0, WANT_PREDICT}, // empty line
        '{1'b0, 8'hAA, 1'b1, WANT_PREDICT},
        '{1'b1, 8'd254, 1'b0, WANT_PREDICT},         // limit one below its highest
        '{1'b0, "a", 1'b0, WANT_PREDICT},
        '{1'b0, "j", 1'b0, WANT_PREDICT},
        '{1'b0, "u", 1'b0, WANT_PREDICT},
        '{1'b0, "d", 1'b0, WANT_PREDICT},
        '{1'b0, "S", 1'b0, WANT_PREDICT},
        '{1'b0, "O", 1'b0, WANT_PREDICT},
        '{1'b0, "S", 1'b0, WANT_PREDICT},
        '{1'b0, 8'h01, 1'b1, WANT_PREDICT}           // two keywords in one line
    };

    // Predictor state
    logic [7:0]                    line_hist [HIST_DEPTH];
    logic [KW_COUNT-1:0]           kw_seen;
    logic [kls_pkg::LEN_W-1:0]     line_len;
    logic                          line_open;
    logic                          prior_hit;
    logic [kls_pkg::VERDICT_W-1:0] spam_code;
    logic [kls_pkg::LEN_W-1:0]     line_limit;

    logic [kls_pkg::VERDICT_W-1:0] verdicts_due [$];
    logic [7:0]                    msg_bytes [$];

    bit idle_en = 1'b1;
    bit rx_hold_request = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int phase_items = 0;
    int verdicts_sent = 0;
    int settings_used = 0;
    int verdict_tally [4] = '{0, 0, 0, 0};

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #(LIMIT_NS);
        $display("Timeout at %0t ns, %0d verdicts still due", $time, verdicts_due.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic flag(input string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Clear all message state
    function automatic void clear_message();
        for (int i = 0; i < HIST_DEPTH; i++) line_hist[i] = '0;
        kw_seen = '0;
        line_len = '0;
        line_open = 1'b0;
        prior_hit = 1'b0;
        spam_code = kls_pkg::VERDICT_INBOX;
    endfunction

    function automatic logic word_ends_here(input int k, input logic [7:0] c);
        string w;
        int n;
        logic hit;
        w = kw_words[k];
        n = w.len();
        hit = (w[n-1] == c);
        for (int j = 1; j < n; j++)
            if (line_hist[j-1] != w[n-1-j]) hit = 1'b0;
        return hit;
    endfunction

    // Latch the first spam reason that applies, then drop the line
    function automatic void close_line();
        if (spam_code == kls_pkg::VERDICT_INBOX) begin
            if (line_len > line_limit)
                spam_code = kls_pkg::VERDICT_LONG_LINE;
            else if ((kw_seen & (kw_seen - 1'b1)) != '0)
                spam_code = kls_pkg::VERDICT_MULTI_KW;
            else if (kw_seen != '0 && prior_hit)
                spam_code = kls_pkg::VERDICT_TWO_LINES;
            else if (kw_seen != '0)
                prior_hit = 1'b1;
        end
        kw_seen = '0;
        line_len = '0;
        line_open = 1'b0;
        for (int i = 0; i < HIST_DEPTH; i++) line_hist[i] = '0;
    endfunction

    function automatic void take_byte(input logic [7:0] c);
        for (int k = 0; k < KW_COUNT; k++)
            if (word_ends_here(k, c)) kw_seen[k] = 1'b1;
        for (int i = HIST_DEPTH - 1; i > 0; i--) line_hist[i] = line_hist[i-1];
        line_hist[0] = c;
        if (line_len != kls_pkg::LEN_SATURATED) line_len = line_len + 1'b1;
        line_open = 1'b1;
    endfunction

    // Advance the predictor by one accepted request
    function automatic void classify(input logic [7:0] c, input logic eom,
                                     output logic emit,
                                     output logic [kls_pkg::VERDICT_W-1:0] verdict);
        emit = 1'b0;
        verdict = kls_pkg::VERDICT_INBOX;
        if (eom) begin
            if (line_open) close_line();
            emit = 1'b1;
            verdict = spam_code;
            clear_message();
        end else if (c == kls_pkg::CHAR_LF) begin
            close_line();
        end else if (c != kls_pkg::CHAR_CR) begin
            take_byte(c);
        end
    endfunction

    // Offer one request; entered and left at a falling edge
    task automatic offer(input logic [7:0] c, input logic eom, input logic [2:0] want);
        logic emit;
        logic [kls_pkg::VERDICT_W-1:0] verdict;
        while (idle_en && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_byte <= c;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        classify(c, eom, emit, verdict);
        if (emit) begin
            if (want != WANT_PREDICT) verdict = want[kls_pkg::VERDICT_W-1:0];
            verdicts_due.push_back(verdict);
            verdict_tally[verdict]++;
            verdicts_sent++;
        end
        items_sent++;
        phase_items++;
        @(negedge i_clk);
    endtask

    // One APB transfer: setup, access, release
    task automatic apb_transfer(input logic wr, input logic [7:0] data, output logic [7:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {kls_pkg::REG_MAX_LINE_LENGTH, 2'b00};
        pwdata <= {{(kls_pkg::APB_DATA_W-8){1'b0}}, data};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata[7:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drain the block, then write the limit and read it back
    task automatic set_limit(input logic [7:0] value);
        logic [7:0] rd;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        apb_transfer(1'b1, value, rd);
        line_limit = value;
        apb_transfer(1'b0, 8'h00, rd);
        if (rd !== value)
            flag($sformatf("max_line_length read %0d, written %0d", rd, value));
        settings_used++;
    endtask

    task automatic add_filler(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 25)
                msg_bytes.push_back(8'($urandom_range(255)));
            else
                msg_bytes.push_back(filler_chars[$urandom_range(filler_chars.len() - 1)]);
        end
    endtask

    // Append a keyword, sometimes cut short, sometimes split by carriage returns
    task automatic add_keyword();
        string w;
        int n;
        w = kw_words[$urandom_range(KW_COUNT - 1)];
        n = w.len();
        if ($urandom_range(99) < 15) n = $urandom_range(n - 1, 1);
        for (int i = 0; i < n; i++) begin
            msg_bytes.push_back(w[i]);
            if ($urandom_range(99) < 8) msg_bytes.push_back(kls_pkg::CHAR_CR);
        end
    endtask

    // Build and send one message of a few lines, mostly with zero to two keywords
    task automatic send_message();
        int lines;
        int hits;
        int r;
        msg_bytes.delete();
        lines = $urandom_range(4);
        for (int l = 0; l < lines; l++) begin
            r = $urandom_range(99);
            hits = (r < 50) ? 0 : (r < 85) ? 1 : 2;
            for (int h = 0; h < hits; h++) begin
                add_filler($urandom_range(5));
                add_keyword();
            end
            if ($urandom_range(24) == 0)
                add_filler($urandom_range(300, 70));
            else
                add_filler($urandom_range(5));
            if (l != lines - 1 || $urandom_range(1))
                msg_bytes.push_back(kls_pkg::CHAR_LF);
        end
        foreach (msg_bytes[i]) offer(msg_bytes[i], 1'b0, WANT_PREDICT);
        offer(8'($urandom_range(255)), 1'b1, WANT_PREDICT);
    endtask

    // Receiver: random stalls, a long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (!idle_en || $urandom_range(99) >= 35);
            end
        end
    end

    // Check each verdict against the oldest one due
    initial begin
        logic [kls_pkg::VERDICT_W-1:0] due;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    flag($sformatf("verdict %0d with none due", o_verdict));
                end else begin
                    due = verdicts_due.pop_front();
                    if (o_verdict !== due)
                        flag($sformatf("verdict %0d, predicted %0d", o_verdict, due));
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [7:0] limits [6];
        line_limit = kls_pkg::MAX_LINE_LENGTH_RESET;
        clear_message();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg)
                set_limit(dir_rows[i].data);
            else
                offer(dir_rows[i].data, dir_rows[i].eom, dir_rows[i].want);
        end

        // Random messages over several limits
        limits[0] = 8'd254;
        limits[1] = 8'd0;
        limits[2] = 8'd255;
        limits[3] = 8'($urandom_range(40, 1));
        limits[4] = kls_pkg::MAX_LINE_LENGTH_RESET;
        limits[5] = 8'($urandom_range(254));
        for (int p = 0; p < 6; p++) begin
            set_limit(limits[p]);
            idle_en = (p != 2);
            if (p == 4) rx_hold_request = 1'b1;
            phase_items = 0;
            while (phase_items < 170) send_message();
        end
        while (verdicts_sent < 48) send_message();

        // Drain and settle
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests in %0d messages under %0d limit settings",
                 items_sent, verdicts_sent, settings_used);
        $display("Verdicts: inbox %0d, long line %0d, two keywords %0d, two lines %0d",
                 verdict_tally[kls_pkg::VERDICT_INBOX],
                 verdict_tally[kls_pkg::VERDICT_LONG_LINE],
                 verdict_tally[kls_pkg::VERDICT_MULTI_KW],
                 verdict_tally[kls_pkg::VERDICT_TWO_LINES]);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/kls_pkg.sv
src/kls_matcher.sv
src/kls_line_close.sv
src/keyword_line_spam_classifier.sv
src/kls_checker.sv
bench/testbench.sv
